>>> rtl/core/bss_pkg.sv
// Shared constants, codes and types for the byte substring search core.
package bss_pkg;

    // Longest needle held by the cell row
    localparam int unsigned NEEDLE_MAX = 32;
    // Largest offset that can be reported before saturating
    localparam longint unsigned OFFSET_MAX = 64'd65535;
    // Width of the match_offset field
    localparam int unsigned OFF_W = 16;
    localparam longint unsigned FIELD_LIMIT = (64'd1 << OFF_W) - 64'd1;
    localparam longint unsigned OFF_LIMIT =
        (OFFSET_MAX < FIELD_LIMIT) ? OFFSET_MAX : FIELD_LIMIT;

    // Needle length counter holds 0 to NEEDLE_MAX
    localparam int unsigned LEN_W = $clog2(NEEDLE_MAX + 1);
    // Haystack byte count saturates just above the offset limit
    localparam longint unsigned SEEN_CAP = OFFSET_MAX + NEEDLE_MAX + 64'd1;
    localparam int unsigned SEEN_W = $clog2(SEEN_CAP + 64'd1);

    // Item kinds
    localparam logic REQ_NEEDLE   = 1'b0;
    localparam logic REQ_HAYSTACK = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_FOUND      = 2'd0,
        STATUS_NOT_FOUND  = 2'd1,
        STATUS_BAD_NEEDLE = 2'd2
    } status_t;

    // Shift enables fanned out to every cell
    typedef struct packed {
        logic hay_shift;
        logic ndl_shift;
    } cell_ctrl_t;

endpackage

>>> rtl/core/bss_cell.sv
// One cell of the compare row: a haystack window byte, a needle byte and their compare.
module bss_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  bss_pkg::cell_ctrl_t ctrl,
    input  logic [7:0]          hay_in,
    input  logic [7:0]          ndl_in,
    input  logic                active,
    output logic [7:0]          hay_out,
    output logic [7:0]          ndl_out,
    output logic                hit
);
    import bss_pkg::*;

    logic [7:0] hay_reg;
    logic [7:0] hay_next;
    logic [7:0] ndl_reg;
    logic [7:0] ndl_next;

    // Take the neighbour's byte when the row shifts
    always_comb
    begin
        hay_next = ctrl.hay_shift ? hay_in : hay_reg;
        ndl_next = ctrl.ndl_shift ? ndl_in : ndl_reg;
    end

    // Window byte starts at zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hay_reg <= '0;
        end
        else
        begin
            hay_reg <= hay_next;
        end
    end

    // Needle byte is payload only
    always_ff @(posedge clk)
    begin
        ndl_reg <= ndl_next;
    end

    assign hay_out = hay_reg;
    assign ndl_out = ndl_reg;
    // Cells past the needle end always agree
    assign hit = !active || (hay_reg == ndl_reg);

endmodule

>>> rtl/core/byte_substring_search_core.sv
// Top level of the streaming first-occurrence byte substring search.
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  in      | in_valid/in_ready  | req_type, data_byte, is_last
//  out     | out_valid/out_ready| status, match_offset, offset_saturated
//
// A needle item leaves the block idle and ready. Accepting a haystack item
// shifts the byte into the cell row; the compare state then ANDs the row of
// cell compares and loads the result register. The row depth (NEEDLE_MAX
// cells) sets the width of that compare. A result that meets a full output
// register holds the block in the compare state until out_ready frees it.
// Reset clears all control state at once; there is no clearing pass.
module byte_substring_search_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 req_type,
    input  logic [7:0]           data_byte,
    input  logic                 is_last,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           status,
    output logic [bss_pkg::OFF_W-1:0] match_offset,
    output logic                 offset_saturated
);
    import bss_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EVAL = 2'b10
    } state_t;

    state_t               state_reg, state_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic                 complete_reg, complete_next;
    logic                 invalid_reg, invalid_next;
    logic [SEEN_W-1:0]    seen_reg, seen_next;
    logic                 reported_reg, reported_next;
    logic                 last_reg, last_next;
    logic                 out_valid_reg, out_valid_next;
    status_t              status_reg, status_next;
    logic [OFF_W-1:0]     offset_reg, offset_next;
    logic                 sat_reg, sat_next;

    cell_ctrl_t           ctrl;
    logic [7:0]           hay_chain [NEEDLE_MAX+1];
    logic [7:0]           ndl_chain [NEEDLE_MAX+1];
    logic [NEEDLE_MAX-1:0] active;
    logic [NEEDLE_MAX-1:0] hit;

    logic                 accept;
    logic                 out_free;
    logic                 ndl_ok;
    logic                 found;
    logic [SEEN_W-1:0]    len_ext;
    logic [SEEN_W-1:0]    off_full;
    logic                 off_sat;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Feed the row: new bytes enter cell 0, older ones move outwards
    assign hay_chain[0] = data_byte;
    assign ndl_chain[0] = data_byte;
    assign ctrl.hay_shift = accept && (req_type == REQ_HAYSTACK);
    assign ctrl.ndl_shift = accept && (req_type == REQ_NEEDLE) &&
                            (complete_reg || (len_reg < LEN_W'(NEEDLE_MAX)));

    // Build the cell row
    for (genvar i = 0; i < NEEDLE_MAX; i++)
    begin : g_cell
        assign active[i] = (len_reg > LEN_W'(i));
        bss_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .hay_in  (hay_chain[i]),
            .ndl_in  (ndl_chain[i]),
            .active  (active[i]),
            .hay_out (hay_chain[i+1]),
            .ndl_out (ndl_chain[i+1]),
            .hit     (hit[i])
        );
    end

    // Window compare and offset for the byte just shifted in
    assign len_ext  = SEEN_W'(len_reg);
    assign ndl_ok   = !invalid_reg && (len_reg != '0);
    assign found    = ndl_ok && !reported_reg && (seen_reg >= len_ext) && (&hit);
    assign off_full = seen_reg - len_ext;
    assign off_sat  = (64'(off_full) > OFF_LIMIT);

    // Sequence needle loading, haystack counting and result issue
    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        complete_next  = complete_reg;
        invalid_next   = invalid_reg;
        seen_next      = seen_reg;
        reported_next  = reported_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        offset_next    = offset_reg;
        sat_next       = sat_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_type == REQ_NEEDLE))
                begin
                    if (complete_reg)
                    begin
                        // Start a fresh needle and drop the search state
                        len_next      = LEN_W'(1);
                        invalid_next  = 1'b0;
                        seen_next     = '0;
                        reported_next = 1'b0;
                    end
                    else if (len_reg < LEN_W'(NEEDLE_MAX))
                    begin
                        len_next = len_reg + LEN_W'(1);
                    end
                    else
                    begin
                        invalid_next = 1'b1;
                    end
                    complete_next = is_last;
                end
                else if (accept)
                begin
                    // Close any open needle and count the haystack byte
                    complete_next = 1'b1;
                    if (64'(seen_reg) < SEEN_CAP)
                    begin
                        seen_next = seen_reg + SEEN_W'(1);
                    end
                    last_next  = is_last;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (found)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = STATUS_FOUND;
                        offset_next    = off_sat ? OFF_LIMIT[OFF_W-1:0] : off_full[OFF_W-1:0];
                        sat_next       = off_sat;
                        reported_next  = !last_reg;
                        if (last_reg)
                        begin
                            seen_next = '0;
                        end
                        state_next = ST_IDLE;
                    end
                end
                else if (last_reg)
                begin
                    if (reported_reg || out_free)
                    begin
                        // Report the end of the haystack unless a match went out
                        if (!reported_reg)
                        begin
                            out_valid_next = 1'b1;
                            status_next    = ndl_ok ? STATUS_NOT_FOUND : STATUS_BAD_NEEDLE;
                            offset_next    = '0;
                            sat_next       = 1'b0;
                        end
                        seen_next     = '0;
                        reported_next = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            complete_reg  <= 1'b1;
            invalid_reg   <= 1'b0;
            seen_reg      <= '0;
            reported_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            complete_reg  <= complete_next;
            invalid_reg   <= invalid_next;
            seen_reg      <= seen_next;
            reported_reg  <= reported_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        last_reg   <= last_next;
        status_reg <= status_next;
        offset_reg <= offset_next;
        sat_reg    <= sat_next;
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign match_offset     = offset_reg;
    assign offset_saturated = sat_reg;

endmodule

>>> test/testbench.sv
// Self-checking testbench for the streaming byte substring search core.
`timescale 1ns / 100ps

module testbench;

    import bss_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
        logic       is_last;
    } search_item_t;

    typedef struct packed {
        status_t          status;
        logic [OFF_W-1:0] offset;
        logic             saturated;
    } search_result_t;

    typedef logic [7:0] byte_q_t[$];

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic             req_type = 1'b0;
    logic [7:0]       data_byte = 8'h00;
    logic             is_last = 1'b0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [1:0]       status;
    logic [OFF_W-1:0] match_offset;
    logic             offset_saturated;

    byte_substring_search_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .req_type         (req_type),
        .data_byte        (data_byte),
        .is_last          (is_last),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .match_offset     (match_offset),
        .offset_saturated (offset_saturated)
    );

    // Clock: 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predicted search state
    logic [7:0]        ndl_bytes [NEEDLE_MAX];
    int unsigned       ndl_len = 0;
    bit                ndl_done = 1'b1;
    bit                ndl_bad = 1'b0;
    logic [7:0]        win [NEEDLE_MAX];
    longint unsigned   hay_seen = 0;
    bit                hit_reported = 1'b0;

    search_item_t      queued_bytes[$];
    search_result_t    predicted_results[$];

    int unsigned       failures = 0;
    int unsigned       items_accepted = 0;
    int unsigned       results_checked = 0;
    int unsigned       found_count = 0;
    int unsigned       missing_count = 0;
    int unsigned       bad_needle_count = 0;
    int unsigned       saturated_count = 0;
    int unsigned       cycle_count = 0;

    logic [7:0]        alpha [4];
    int unsigned       alpha_n = 0;

    function automatic void clear_window();
        for (int i = 0; i < NEEDLE_MAX; i++)
            win[i] = 8'h00;
        hay_seen = 0;
        hit_reported = 1'b0;
    endfunction

    // Advance the predicted state by one item; return 1 when it yields a result
    function automatic bit search_step(input search_item_t it, output search_result_t res);
        bit              usable;
        bit              hit;
        longint unsigned off;
        res = '{STATUS_FOUND, '0, 1'b0};
        if (it.req_type == REQ_NEEDLE)
        begin
            if (ndl_done)
            begin
                ndl_len = 0;
                ndl_bad = 1'b0;
                ndl_done = 1'b0;
                clear_window();
            end
            if (ndl_len < NEEDLE_MAX)
            begin
                ndl_bytes[ndl_len] = it.data_byte;
                ndl_len++;
            end
            else
                ndl_bad = 1'b1;
            if (it.is_last)
                ndl_done = 1'b1;
            return 1'b0;
        end

        ndl_done = 1'b1;
        usable = !ndl_bad && ndl_len != 0;
        for (int i = NEEDLE_MAX - 1; i > 0; i--)
            win[i] = win[i-1];
        win[0] = it.data_byte;
        if (hay_seen < SEEN_CAP)
            hay_seen++;

        hit = usable && !hit_reported && hay_seen >= ndl_len;
        for (int i = 0; i < ndl_len; i++)
            if (win[i] != ndl_bytes[ndl_len - 1 - i])
                hit = 1'b0;

        if (hit)
        begin
            off = hay_seen - ndl_len;
            res.saturated = off > OFF_LIMIT;
            res.offset = res.saturated ? OFF_W'(OFF_LIMIT) : OFF_W'(off);
            hit_reported = 1'b1;
            if (it.is_last)
                clear_window();
            return 1'b1;
        end

        if (it.is_last)
        begin
            hit = !hit_reported;
            clear_window();
            if (hit)
            begin
                res.status = usable ? STATUS_NOT_FOUND : STATUS_BAD_NEEDLE;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        if (r < 98)
            return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic [7:0] pick_byte();
        if (alpha_n == 0)
            return 8'($urandom_range(255));
        return alpha[$urandom_range(alpha_n - 1)];
    endfunction

    task automatic queue_byte(input logic kind, input logic [7:0] b, input logic last);
        queued_bytes.push_back('{kind, b, last});
    endtask

    task automatic queue_needle(input byte_q_t bytes, input bit close);
        for (int i = 0; i < bytes.size(); i++)
            queue_byte(REQ_NEEDLE, bytes[i], close && i == bytes.size() - 1);
    endtask

    // Hold the sender off until every item is taken and every result is back
    task automatic drain_results();
        while (queued_bytes.size() != 0 || in_valid || predicted_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Driver: present queued items, predict at acceptance
    search_item_t   drv_item;
    search_result_t drv_res;
    int unsigned    send_gap = 0;
    bit             send_quiet = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            req_type  <= 1'b0;
            data_byte <= 8'h00;
            is_last   <= 1'b0;
            send_gap  <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (search_step(drv_item, drv_res))
                    predicted_results.push_back(drv_res);
                items_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (queued_bytes.size() != 0)
                begin
                    drv_item = queued_bytes.pop_front();
                    req_type  <= drv_item.req_type;
                    data_byte <= drv_item.data_byte;
                    is_last   <= drv_item.is_last;
                    in_valid  <= 1'b1;
                    // flip between idling and back-to-back stretches
                    if ($urandom_range(49) == 0)
                        send_quiet = !send_quiet;
                    send_gap <= send_quiet ? 0 : pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: stall the result channel and check each result item
    search_result_t want;
    int unsigned    recv_gap = 0;
    bit             recv_quiet = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    $error("unexpected result: status %0d offset %0d saturated %0d",
                           status, match_offset, offset_saturated);
                    failures++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    results_checked++;
                    case (want.status)
                        STATUS_FOUND:     found_count++;
                        STATUS_NOT_FOUND: missing_count++;
                        default:          bad_needle_count++;
                    endcase
                    if (want.saturated)
                        saturated_count++;
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        failures++;
                    end
                    if (match_offset !== want.offset)
                    begin
                        $error("match_offset: expected %0d, got %0d", want.offset, match_offset);
                        failures++;
                    end
                    if (offset_saturated !== want.saturated)
                    begin
                        $error("offset_saturated: expected %0d, got %0d",
                               want.saturated, offset_saturated);
                        failures++;
                    end
                end
            end
            if (recv_gap != 0)
            begin
                recv_gap  <= recv_gap - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(49) == 0)
                    recv_quiet = !recv_quiet;
                recv_gap <= recv_quiet ? 0 : pick_gap();
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d results outstanding",
                   cycle_count, predicted_results.size());
            $display("byte_substring_search_core regression: fail");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        byte_q_t     needle;
        byte_q_t     hay;
        int unsigned random_count;
        int unsigned nlen;
        int unsigned hlen;
        int unsigned pos;
        int unsigned r;
        bit          have_needle;
        bit          plant;
        bit          close;
        bit          paused;

        random_count = 0;
        have_needle = 1'b0;
        paused = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // haystack before any needle: empty needle
        queue_byte(REQ_HAYSTACK, 8'h00, 1'b1);
        // single-byte needle matching on the final haystack byte
        queue_byte(REQ_NEEDLE, 8'hFF, 1'b1);
        queue_byte(REQ_HAYSTACK, 8'h00, 1'b0);
        queue_byte(REQ_HAYSTACK, 8'hFF, 1'b1);
        // match at offset zero, then further bytes and a second match give nothing
        queue_needle('{8'h00, 8'hFF}, 1'b1);
        queue_byte(REQ_HAYSTACK, 8'h00, 1'b0);
        queue_byte(REQ_HAYSTACK, 8'hFF, 1'b0);
        queue_byte(REQ_HAYSTACK, 8'h00, 1'b0);
        queue_byte(REQ_HAYSTACK, 8'hFF, 1'b1);
        // new haystack, same needle, no match
        queue_byte(REQ_HAYSTACK, 8'h12, 1'b0);
        queue_byte(REQ_HAYSTACK, 8'h34, 1'b1);
        // needle left open, closed by the first haystack byte
        queue_needle('{8'hAB, 8'hCD}, 1'b0);
        queue_byte(REQ_HAYSTACK, 8'hAB, 1'b0);
        queue_byte(REQ_HAYSTACK, 8'hCD, 1'b1);
        // needle byte in mid haystack restarts the search
        queue_byte(REQ_NEEDLE, 8'h22, 1'b1);
        queue_byte(REQ_HAYSTACK, 8'h11, 1'b0);
        queue_byte(REQ_NEEDLE, 8'h22, 1'b1);
        queue_byte(REQ_HAYSTACK, 8'h22, 1'b1);
        drain_results();

        // full-length needle found at offset three
        needle.delete();
        repeat (NEEDLE_MAX) needle.push_back(8'($urandom_range(255)));
        queue_needle(needle, 1'b1);
        repeat (3) queue_byte(REQ_HAYSTACK, ~needle[0], 1'b0);
        for (int i = 0; i < NEEDLE_MAX; i++)
            queue_byte(REQ_HAYSTACK, needle[i], i == NEEDLE_MAX - 1);
        // over-long needle: no compare, invalid at the end of the haystack
        needle.push_back(8'h5A);
        queue_needle(needle, 1'b1);
        for (int i = 0; i < NEEDLE_MAX; i++)
            queue_byte(REQ_HAYSTACK, needle[i], i == NEEDLE_MAX - 1);
        drain_results();

        // random traffic: mostly well-formed needle and haystack runs
        while (random_count < 1250)
        begin
            if (!paused && random_count >= 600)
            begin
                drain_results();
                paused = 1'b1;
            end
            r = $urandom_range(99);
            if (r < 15)
            begin
                // noise: any field, any order
                nlen = $urandom_range(6, 1);
                repeat (nlen)
                    queue_byte(1'($urandom_range(1)), 8'($urandom_range(255)),
                               1'($urandom_range(1)));
                random_count += nlen;
                have_needle = 1'b0;
            end
            else
            begin
                alpha_n = $urandom_range(1) ? $urandom_range(4, 2) : 0;
                for (int i = 0; i < 4; i++)
                    alpha[i] = 8'($urandom_range(255));
                if (!have_needle || $urandom_range(4) != 0)
                begin
                    r = $urandom_range(99);
                    if (r < 65)
                        nlen = $urandom_range(4, 1);
                    else if (r < 88)
                        nlen = $urandom_range(NEEDLE_MAX - 1, 5);
                    else if (r < 95)
                        nlen = NEEDLE_MAX;
                    else
                        nlen = $urandom_range(NEEDLE_MAX + 4, NEEDLE_MAX + 1);
                    needle.delete();
                    repeat (nlen) needle.push_back(pick_byte());
                    queue_needle(needle, $urandom_range(9) != 0);
                    random_count += nlen;
                    have_needle = 1'b1;
                end
                plant = ($urandom_range(99) < 60) && needle.size() <= NEEDLE_MAX;
                hlen = plant ? needle.size() + $urandom_range(40) : $urandom_range(40, 1);
                hay.delete();
                repeat (hlen) hay.push_back(pick_byte());
                if (plant)
                begin
                    pos = $urandom_range(hlen - needle.size());
                    for (int i = 0; i < needle.size(); i++)
                        hay[pos + i] = needle[i];
                end
                close = $urandom_range(19) != 0;
                for (int i = 0; i < hlen; i++)
                    queue_byte(REQ_HAYSTACK, hay[i], close && i == hlen - 1);
                random_count += hlen;
            end
        end

        drain_results();
        repeat (20) @(negedge clk);

        $display("covered %0d items: %0d results checked",
                 items_accepted, results_checked);
        $display("  %0d found, %0d not found, %0d bad needle, %0d saturated",
                 found_count, missing_count, bad_needle_count, saturated_count);
        if (failures == 0 && predicted_results.size() == 0)
            $display("byte_substring_search_core regression: pass");
        else
            $display("byte_substring_search_core regression: fail");
        $finish;
    end

endmodule
